[sv/ctasg_pkg.sv]
// Shared types and constants of the three-axis step generator.
// Payload structs, opcode and register index codes, sequencer states.
// Depends on nothing.
package ctasg_pkg;

    localparam int AXES       = 3;
    localparam int AXIS_IDX_W = 2;
    localparam int POS_W      = 24;
    localparam int SPD_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // 256e6 * maxd is computed as (15625 * maxd) << 14
    localparam int NUM_SHIFT  = 14;
    localparam int NUM_PROD_W = 38;
    localparam int NUM_W      = NUM_PROD_W + NUM_SHIFT;
    localparam int DEN_W      = 56;
    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = 24;
    localparam int DIV_CNT_W  = 6;

    localparam logic [MUL_A_W-1:0] NUM_SCALE     = 32'd15625;
    localparam logic [19:0]        IDLE_INTERVAL = 20'd1000000;
    localparam logic [19:0]        MIN_INTERVAL  = 20'd50;

    localparam logic signed [POS_W-1:0] RESET_POS [AXES] = '{24'sd0, 24'sd450, 24'sd0};
    localparam logic [SPD_W-1:0] RESET_SPD   = 16'd1280;
    localparam logic [SPD_W-1:0] RESET_SPEED = 16'd90;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_MOVE = 2'd1;
    localparam logic [1:0] OP_STOP = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SPD_A    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPD_B    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPD_C    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_EN = 3'd4;

    typedef logic signed [POS_W-1:0] pos_arr_t [AXES];

    typedef struct packed {
        logic [1:0]              opcode;
        logic signed [POS_W-1:0] target_position_a;
        logic signed [POS_W-1:0] target_position_b;
        logic signed [POS_W-1:0] target_position_c;
        logic [SPD_W-1:0]        feedrate;
    } in_item_t;

    typedef struct packed {
        logic                    accepted;
        logic                    step_a;
        logic                    step_b;
        logic                    step_c;
        logic                    dir_a;
        logic                    dir_b;
        logic                    dir_c;
        logic                    busy_res;
        logic signed [POS_W-1:0] position_a;
        logic signed [POS_W-1:0] position_b;
        logic signed [POS_W-1:0] position_c;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK,
        ST_DIST,
        ST_MUL_NUM,
        ST_AXIS,
        ST_MUL_SD,
        ST_MUL_DEN,
        ST_DIV,
        ST_DIV_END,
        ST_DONE
    } state_t;

endpackage

[sv/coordinated_three_axis_step_generator_unit.sv]
// Top level of the three-axis step generator: sequencer, shared multiplier,
// restoring divider and per-axis motion state.
// Depends on ctasg_pkg.

// One beat in on s_, one beat out on m_ per item; the block takes one item at
// a time and s_ready is high only while the sequencer is idle. A tick goes
// straight to the result when motion is off or the drive is disabled, and
// otherwise walks the three axes (one elapsed-time compare per axis per cycle).
// A stop, a rejected move or an unknown opcode goes straight to the result. An
// accepted move runs accept, one distance step per axis, the numerator
// multiply and the result cycle, plus, for each axis with a nonzero distance,
// one select step, two multiplies, a restoring division and a clamp of the
// result; axes with zero distance cost only the select step, and a move whose
// distances are all zero skips the multiply and goes to the result. The result
// cycle holds while the result register is still full and m_ready is low. The
// result register decouples the two sides: the next beat is taken while a
// finished result still waits on m_ready.
module coordinated_three_axis_step_generator_unit #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [ctasg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ctasg_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  ctasg_pkg::in_item_t                    s_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output ctasg_pkg::out_item_t                   m_data
);

    localparam int AXES = ctasg_pkg::AXES;
    localparam int IW   = ctasg_pkg::AXIS_IDX_W;
    localparam int CW   = (ctasg_pkg::NUM_W > TIME_WIDTH) ? ctasg_pkg::NUM_W : TIME_WIDTH;
    localparam int PW   = ctasg_pkg::POS_W;
    localparam int NW   = ctasg_pkg::NUM_W;
    localparam int DW   = ctasg_pkg::DEN_W;

    // Sequencer
    ctasg_pkg::state_t state_reg, state_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [ctasg_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;

    // Configuration
    logic [ctasg_pkg::SPD_W-1:0] spd_reg [AXES];
    logic [ctasg_pkg::SPD_W-1:0] spd_next [AXES];
    logic [ctasg_pkg::SPD_W-1:0] dflt_speed_reg, dflt_speed_next;
    logic                        drive_en_reg, drive_en_next;

    // Motion state
    ctasg_pkg::pos_arr_t pos_reg, pos_next;
    ctasg_pkg::pos_arr_t tgt_reg, tgt_next;
    logic [TIME_WIDTH-1:0] interval_reg [AXES];
    logic [TIME_WIDTH-1:0] interval_next [AXES];
    logic [TIME_WIDTH-1:0] last_reg [AXES];
    logic [TIME_WIDTH-1:0] last_next [AXES];
    logic [TIME_WIDTH-1:0] clk_reg, clk_next;
    logic                  motion_reg, motion_next;

    // Per-item scratch
    logic [1:0]            op_reg, op_next;
    logic                  accepted_reg, accepted_next;
    logic [AXES-1:0]       dir_reg, dir_next;
    logic [AXES-1:0]       step_reg, step_next;
    logic                  all_done_reg, all_done_next;
    logic [PW-1:0]         dist_reg [AXES];
    logic [PW-1:0]         dist_next [AXES];
    logic [PW-1:0]         maxd_reg, maxd_next;
    logic [ctasg_pkg::SPD_W-1:0] speed_reg, speed_next;
    logic [ctasg_pkg::NUM_PROD_W-1:0] num_reg, num_next;
    logic [ctasg_pkg::MUL_A_W-1:0]    prod_reg, prod_next;
    logic [DW-1:0]         den_reg, den_next;
    logic [DW-1:0]         rem_reg, rem_next;
    logic [NW-1:0]         dvd_reg, dvd_next;

    // Result register
    logic                  m_valid_reg, m_valid_next;
    ctasg_pkg::out_item_t  out_reg, out_next;

    // Shared datapath signals
    logic                  s_fire;
    logic                  last_axis;
    logic [AXES-1:0]       dir_now;
    logic signed [PW:0]    diff_w;
    logic [PW-1:0]         dist_w;
    logic [PW-1:0]         maxd_w;
    logic [ctasg_pkg::MUL_A_W-1:0] mul_a;
    logic [ctasg_pkg::MUL_B_W-1:0] mul_b;
    logic [DW-1:0]         mul_p;
    logic [DW:0]           rem_sh;
    logic                  div_ge;
    logic [TIME_WIDTH-1:0] elapsed;
    logic                  due;
    logic [CW-1:0]         q_ext;
    logic [TIME_WIDTH-1:0] interval_sat;

    assign s_ready   = (state_reg == ctasg_pkg::ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign last_axis = (idx_reg == IW'(AXES - 1));
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            dir_now[i] = tgt_reg[i] > pos_reg[i];
        end
    end

    // Distance of the selected axis and running maximum
    assign diff_w = {tgt_reg[idx_reg][PW-1], tgt_reg[idx_reg]}
                  - {pos_reg[idx_reg][PW-1], pos_reg[idx_reg]};
    assign dist_w = diff_w[PW] ? PW'(-diff_w) : diff_w[PW-1:0];
    assign maxd_w = (dist_w > maxd_reg) ? dist_w : maxd_reg;

    // Shared multiplier: operands follow the sequencer
    always_comb begin
        unique case (state_reg)
            ctasg_pkg::ST_MUL_NUM: begin
                mul_a = ctasg_pkg::NUM_SCALE;
                mul_b = maxd_reg;
            end
            ctasg_pkg::ST_MUL_SD: begin
                mul_a = ctasg_pkg::MUL_A_W'(speed_reg);
                mul_b = ctasg_pkg::MUL_B_W'(spd_reg[idx_reg]);
            end
            default: begin
                mul_a = prod_reg;
                mul_b = dist_reg[idx_reg];
            end
        endcase
    end
    assign mul_p = DW'(mul_a) * DW'(mul_b);

    // One restoring division step per cycle; quotient shifts into dvd_reg
    assign rem_sh = {rem_reg, dvd_reg[NW-1]};
    assign div_ge = rem_sh >= {1'b0, den_reg};

    // Elapsed time since the selected axis last stepped, modulo the clock width
    assign elapsed = clk_reg - last_reg[idx_reg];
    assign due     = elapsed >= interval_reg[idx_reg];

    // Clamp the quotient: zero divisor or overflow saturates, floor of 50 us
    assign q_ext = CW'(dvd_reg);
    always_comb begin
        if (den_reg == '0 || q_ext > CW'({TIME_WIDTH{1'b1}})) begin
            interval_sat = '1;
        end else if (q_ext < CW'(ctasg_pkg::MIN_INTERVAL)) begin
            interval_sat = TIME_WIDTH'(ctasg_pkg::MIN_INTERVAL);
        end else begin
            interval_sat = TIME_WIDTH'(q_ext);
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ctasg_pkg::ST_IDLE: begin
                if (s_fire) begin
                    case (s_data.opcode)
                        ctasg_pkg::OP_TICK: begin
                            state_next = (motion_reg && drive_en_reg) ? ctasg_pkg::ST_TICK
                                                                      : ctasg_pkg::ST_DONE;
                        end
                        ctasg_pkg::OP_MOVE: begin
                            state_next = drive_en_reg ? ctasg_pkg::ST_DIST : ctasg_pkg::ST_DONE;
                        end
                        default: state_next = ctasg_pkg::ST_DONE;
                    endcase
                end
            end
            ctasg_pkg::ST_TICK: begin
                if (last_axis) state_next = ctasg_pkg::ST_DONE;
            end
            ctasg_pkg::ST_DIST: begin
                if (last_axis) begin
                    state_next = (maxd_w == '0) ? ctasg_pkg::ST_DONE : ctasg_pkg::ST_MUL_NUM;
                end
            end
            ctasg_pkg::ST_MUL_NUM: state_next = ctasg_pkg::ST_AXIS;
            ctasg_pkg::ST_AXIS: begin
                if (dist_reg[idx_reg] != '0) begin
                    state_next = ctasg_pkg::ST_MUL_SD;
                end else if (last_axis) begin
                    state_next = ctasg_pkg::ST_DONE;
                end
            end
            ctasg_pkg::ST_MUL_SD:  state_next = ctasg_pkg::ST_MUL_DEN;
            ctasg_pkg::ST_MUL_DEN: state_next = ctasg_pkg::ST_DIV;
            ctasg_pkg::ST_DIV: begin
                if (cnt_reg == ctasg_pkg::DIV_CNT_W'(NW - 1)) state_next = ctasg_pkg::ST_DIV_END;
            end
            ctasg_pkg::ST_DIV_END: begin
                state_next = last_axis ? ctasg_pkg::ST_DONE : ctasg_pkg::ST_AXIS;
            end
            ctasg_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) state_next = ctasg_pkg::ST_IDLE;
            end
            default: state_next = ctasg_pkg::ST_IDLE;
        endcase
    end

    // Datapath and register updates
    always_comb begin
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        spd_next        = spd_reg;
        dflt_speed_next = dflt_speed_reg;
        drive_en_next   = drive_en_reg;
        pos_next        = pos_reg;
        tgt_next        = tgt_reg;
        interval_next   = interval_reg;
        last_next       = last_reg;
        clk_next        = clk_reg;
        motion_next     = motion_reg;
        op_next         = op_reg;
        accepted_next   = accepted_reg;
        dir_next        = dir_reg;
        step_next       = step_reg;
        all_done_next   = all_done_reg;
        dist_next       = dist_reg;
        maxd_next       = maxd_reg;
        speed_next      = speed_reg;
        num_next        = num_reg;
        prod_next       = prod_reg;
        den_next        = den_reg;
        rem_next        = rem_reg;
        dvd_next        = dvd_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_next        = out_reg;

        // The user must write configuration only while idle; the block itself does not enforce it
        if (cfg_wr_en) begin
            unique case (cfg_index)
                ctasg_pkg::REG_SPD_A:    spd_next[0]     = cfg_wdata;
                ctasg_pkg::REG_SPD_B:    spd_next[1]     = cfg_wdata;
                ctasg_pkg::REG_SPD_C:    spd_next[2]     = cfg_wdata;
                ctasg_pkg::REG_SPEED:    dflt_speed_next = cfg_wdata;
                ctasg_pkg::REG_DRIVE_EN: drive_en_next   = cfg_wdata[0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ctasg_pkg::ST_IDLE: begin
                if (s_fire) begin
                    op_next       = s_data.opcode;
                    accepted_next = 1'b1;
                    step_next     = '0;
                    idx_next      = '0;
                    case (s_data.opcode)
                        ctasg_pkg::OP_TICK: begin
                            // Direction is taken before any axis steps
                            clk_next      = clk_reg + 1'b1;
                            dir_next      = dir_now;
                            all_done_next = 1'b1;
                        end
                        ctasg_pkg::OP_MOVE: begin
                            if (drive_en_reg) begin
                                tgt_next[0] = s_data.target_position_a;
                                tgt_next[1] = s_data.target_position_b;
                                tgt_next[2] = s_data.target_position_c;
                                speed_next  = (s_data.feedrate == '0) ? dflt_speed_reg
                                                                     : s_data.feedrate;
                                maxd_next   = '0;
                                motion_next = 1'b1;
                            end else begin
                                accepted_next = 1'b0;
                            end
                        end
                        ctasg_pkg::OP_STOP: begin
                            motion_next = 1'b0;
                            tgt_next    = pos_reg;
                        end
                        default: accepted_next = 1'b0;
                    endcase
                end
            end
            ctasg_pkg::ST_TICK: begin
                if (pos_reg[idx_reg] != tgt_reg[idx_reg]) begin
                    all_done_next = 1'b0;
                    if (due) begin
                        pos_next[idx_reg]  = dir_reg[idx_reg] ? pos_reg[idx_reg] + 1'b1
                                                              : pos_reg[idx_reg] - 1'b1;
                        last_next[idx_reg] = clk_reg;
                        step_next[idx_reg] = 1'b1;
                    end
                end
                if (last_axis) begin
                    if (all_done_reg && pos_reg[idx_reg] == tgt_reg[idx_reg]) begin
                        motion_next = 1'b0;
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ctasg_pkg::ST_DIST: begin
                dist_next[idx_reg] = dist_w;
                maxd_next          = maxd_w;
                idx_next           = last_axis ? '0 : idx_reg + 1'b1;
            end
            ctasg_pkg::ST_MUL_NUM: begin
                num_next = mul_p[ctasg_pkg::NUM_PROD_W-1:0];
            end
            ctasg_pkg::ST_AXIS: begin
                if (dist_reg[idx_reg] == '0) begin
                    interval_next[idx_reg] = TIME_WIDTH'(ctasg_pkg::IDLE_INTERVAL);
                    if (!last_axis) idx_next = idx_reg + 1'b1;
                end
            end
            ctasg_pkg::ST_MUL_SD: begin
                prod_next = mul_p[ctasg_pkg::MUL_A_W-1:0];
            end
            ctasg_pkg::ST_MUL_DEN: begin
                den_next = mul_p;
                rem_next = '0;
                dvd_next = {num_reg, {ctasg_pkg::NUM_SHIFT{1'b0}}};
                cnt_next = '0;
            end
            ctasg_pkg::ST_DIV: begin
                rem_next = div_ge ? DW'(rem_sh - {1'b0, den_reg}) : rem_sh[DW-1:0];
                dvd_next = {dvd_reg[NW-2:0], div_ge};
                cnt_next = cnt_reg + 1'b1;
            end
            ctasg_pkg::ST_DIV_END: begin
                interval_next[idx_reg] = interval_sat;
                if (!last_axis) idx_next = idx_reg + 1'b1;
            end
            ctasg_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    out_next.accepted   = accepted_reg;
                    out_next.step_a     = step_reg[0];
                    out_next.step_b     = step_reg[1];
                    out_next.step_c     = step_reg[2];
                    out_next.dir_a      = (op_reg == ctasg_pkg::OP_TICK) ? dir_reg[0] : dir_now[0];
                    out_next.dir_b      = (op_reg == ctasg_pkg::OP_TICK) ? dir_reg[1] : dir_now[1];
                    out_next.dir_c      = (op_reg == ctasg_pkg::OP_TICK) ? dir_reg[2] : dir_now[2];
                    out_next.busy_res   = motion_reg;
                    out_next.position_a = pos_reg[0];
                    out_next.position_b = pos_reg[1];
                    out_next.position_c = pos_reg[2];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ctasg_pkg::ST_IDLE;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            dflt_speed_reg <= ctasg_pkg::RESET_SPEED;
            drive_en_reg   <= 1'b0;
            pos_reg        <= ctasg_pkg::RESET_POS;
            tgt_reg        <= ctasg_pkg::RESET_POS;
            clk_reg        <= '0;
            motion_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                spd_reg[i]      <= ctasg_pkg::RESET_SPD;
                interval_reg[i] <= '0;
                last_reg[i]     <= '0;
            end
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            spd_reg        <= spd_next;
            dflt_speed_reg <= dflt_speed_next;
            drive_en_reg   <= drive_en_next;
            pos_reg        <= pos_next;
            tgt_reg        <= tgt_next;
            interval_reg   <= interval_next;
            last_reg       <= last_next;
            clk_reg        <= clk_next;
            motion_reg     <= motion_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Per-item scratch and result payload
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        accepted_reg <= accepted_next;
        dir_reg      <= dir_next;
        step_reg     <= step_next;
        all_done_reg <= all_done_next;
        dist_reg     <= dist_next;
        maxd_reg     <= maxd_next;
        speed_reg    <= speed_next;
        num_reg      <= num_next;
        prod_reg     <= prod_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        dvd_reg      <= dvd_next;
        out_reg      <= out_next;
    end

endmodule

[test/ctasg_motion_checker.sv]
// Scoreboard for the three-axis step generator: mirrors the motion state,
// predicts one report per command beat and compares it with the m_ channel.
// Depends on ctasg_pkg.
module ctasg_motion_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [ctasg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ctasg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  ctasg_pkg::in_item_t                  s_data,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  ctasg_pkg::out_item_t                 m_data,
    output int                                   fail_count,
    output int                                   outstanding,
    output logic signed [ctasg_pkg::POS_W-1:0]   cur_pos_a,
    output logic signed [ctasg_pkg::POS_W-1:0]   cur_pos_b,
    output logic signed [ctasg_pkg::POS_W-1:0]   cur_pos_c
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AXES  = ctasg_pkg::AXES;
    localparam int POS_W = ctasg_pkg::POS_W;
    localparam int SPD_W = ctasg_pkg::SPD_W;

    localparam logic [31:0]     IDLE_PERIOD = 32'd1000000;
    localparam longint unsigned MIN_PERIOD  = 64'd50;
    localparam longint unsigned PERIOD_SAT  = 64'hFFFF_FFFF;

    logic [SPD_W-1:0]        steps_per_deg [AXES];
    logic [SPD_W-1:0]        fallback_speed;
    logic                    drive_on;

    logic signed [POS_W-1:0] axis_pos [AXES];
    logic signed [POS_W-1:0] axis_goal [AXES];
    logic [31:0]             step_period [AXES];
    logic [31:0]             last_step_at [AXES];
    logic [31:0]             usec_now;
    logic                    moving;

    ctasg_pkg::out_item_t expected_reports [$];
    int        mismatches = 0;
    int        backlog    = 0;

    assign fail_count  = mismatches;
    assign outstanding = backlog;
    assign cur_pos_a   = axis_pos[0];
    assign cur_pos_b   = axis_pos[1];
    assign cur_pos_c   = axis_pos[2];

    // Apply one command to the mirrored state and return the report it yields.
    function automatic ctasg_pkg::out_item_t apply_command(input ctasg_pkg::in_item_t cmd);
        ctasg_pkg::out_item_t    rsp;
        logic [AXES-1:0]         stepped;
        logic [AXES-1:0]         toward;
        logic signed [POS_W-1:0] goal [AXES];
        longint unsigned         axis_dist [AXES];
        longint unsigned         maxd, speed, spd, num, den, q;
        int                      diff;
        logic                    all_home;
        logic                    accepted;

        stepped  = '0;
        toward   = '0;
        accepted = 1'b1;
        goal[0]  = cmd.target_position_a;
        goal[1]  = cmd.target_position_b;
        goal[2]  = cmd.target_position_c;

        case (cmd.opcode)
            ctasg_pkg::OP_TICK: begin
                usec_now = usec_now + 32'd1;
                // direction is taken before any axis moves
                for (int i = 0; i < AXES; i++) toward[i] = axis_goal[i] > axis_pos[i];
                if (moving && drive_on) begin
                    all_home = 1'b1;
                    for (int i = 0; i < AXES; i++) begin
                        if (axis_pos[i] != axis_goal[i]) begin
                            all_home = 1'b0;
                            if (usec_now - last_step_at[i] >= step_period[i]) begin
                                axis_pos[i]     = toward[i] ? axis_pos[i] + 24'sd1
                                                            : axis_pos[i] - 24'sd1;
                                last_step_at[i] = usec_now;
                                stepped[i]      = 1'b1;
                            end
                        end
                    end
                    if (all_home) moving = 1'b0;
                end
            end
            ctasg_pkg::OP_MOVE: begin
                if (!drive_on) begin
                    accepted = 1'b0;
                end else begin
                    speed = (cmd.feedrate == '0) ? 64'(fallback_speed) : 64'(cmd.feedrate);
                    maxd  = '0;
                    for (int i = 0; i < AXES; i++) begin
                        axis_goal[i] = goal[i];
                        diff         = int'(axis_goal[i]) - int'(axis_pos[i]);
                        axis_dist[i] = (diff < 0) ? 64'(-diff) : 64'(diff);
                        if (axis_dist[i] > maxd) maxd = axis_dist[i];
                    end
                    // an all-zero move keeps the old periods
                    if (maxd != 0) begin
                        num = 64'd256000000 * maxd;
                        for (int i = 0; i < AXES; i++) begin
                            if (axis_dist[i] == 0) begin
                                step_period[i] = IDLE_PERIOD;
                            end else begin
                                spd = 64'(steps_per_deg[i]);
                                den = speed * axis_dist[i] * spd;
                                q   = (den == 0) ? PERIOD_SAT : num / den;
                                if (q < MIN_PERIOD) q = MIN_PERIOD;
                                if (q > PERIOD_SAT) q = PERIOD_SAT;
                                step_period[i] = q[31:0];
                            end
                        end
                    end
                    moving = 1'b1;
                end
            end
            ctasg_pkg::OP_STOP: begin
                moving = 1'b0;
                for (int i = 0; i < AXES; i++) axis_goal[i] = axis_pos[i];
            end
            default: accepted = 1'b0;
        endcase

        if (cmd.opcode != ctasg_pkg::OP_TICK)
            for (int i = 0; i < AXES; i++) toward[i] = axis_goal[i] > axis_pos[i];

        rsp.accepted   = accepted;
        rsp.step_a     = stepped[0];
        rsp.step_b     = stepped[1];
        rsp.step_c     = stepped[2];
        rsp.dir_a      = toward[0];
        rsp.dir_b      = toward[1];
        rsp.dir_c      = toward[2];
        rsp.busy_res   = moving;
        rsp.position_a = axis_pos[0];
        rsp.position_b = axis_pos[1];
        rsp.position_c = axis_pos[2];
        return rsp;
    endfunction

    task automatic check_bit(input string label, input logic want, input logic got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", label, want, got);
            mismatches++;
        end
    endtask

    task automatic check_pos(input string label, input logic signed [POS_W-1:0] want,
                             input logic signed [POS_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", label, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        ctasg_pkg::out_item_t want;
        if (!aresetn) begin
            for (int i = 0; i < AXES; i++) begin
                steps_per_deg[i] = ctasg_pkg::RESET_SPD;
                axis_pos[i]      = ctasg_pkg::RESET_POS[i];
                axis_goal[i]     = ctasg_pkg::RESET_POS[i];
                step_period[i]   = '0;
                last_step_at[i]  = '0;
            end
            fallback_speed = ctasg_pkg::RESET_SPEED;
            drive_on       = 1'b0;
            usec_now       = '0;
            moving         = 1'b0;
            expected_reports.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    ctasg_pkg::REG_SPD_A:    steps_per_deg[0] = cfg_wdata;
                    ctasg_pkg::REG_SPD_B:    steps_per_deg[1] = cfg_wdata;
                    ctasg_pkg::REG_SPD_C:    steps_per_deg[2] = cfg_wdata;
                    ctasg_pkg::REG_SPEED:    fallback_speed   = cfg_wdata;
                    ctasg_pkg::REG_DRIVE_EN: drive_on         = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) expected_reports.push_back(apply_command(s_data));
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    $error("result beat with no command waiting");
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    check_bit("accepted",   want.accepted,   m_data.accepted);
                    check_bit("step_a",     want.step_a,     m_data.step_a);
                    check_bit("step_b",     want.step_b,     m_data.step_b);
                    check_bit("step_c",     want.step_c,     m_data.step_c);
                    check_bit("dir_a",      want.dir_a,      m_data.dir_a);
                    check_bit("dir_b",      want.dir_b,      m_data.dir_b);
                    check_bit("dir_c",      want.dir_c,      m_data.dir_c);
                    check_bit("busy_res",   want.busy_res,   m_data.busy_res);
                    check_pos("position_a", want.position_a, m_data.position_a);
                    check_pos("position_b", want.position_b, m_data.position_b);
                    check_pos("position_c", want.position_c, m_data.position_c);
                end
            end
        end
        backlog = expected_reports.size();
    end

endmodule

[test/tb_coordinated_three_axis_step_generator_unit.sv]
// Stimulus and verdict for the three-axis step generator: drives commands,
// registers and result back-pressure; ctasg_motion_checker does the checking.
// Depends on ctasg_pkg, ctasg_motion_checker and the block's top level.
module tb_coordinated_three_axis_step_generator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_W      = ctasg_pkg::POS_W;
    localparam int SPD_W      = ctasg_pkg::SPD_W;
    localparam int CFG_IDX_W  = ctasg_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = ctasg_pkg::CFG_DATA_W;

    // opcode the block must answer with accepted low and no state change
    localparam logic [1:0] OP_UNUSED     = 2'd3;
    // margin after the last result, longer than the longest accepted move
    localparam int         SETTLE_CYCLES = 200;
    // receiver hold-off long enough to back the block up into s_ready
    localparam int         LONG_HOLD     = 300;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    ctasg_pkg::in_item_t   s_data;
    logic                  m_valid;
    logic                  m_ready;
    ctasg_pkg::out_item_t  m_data;

    int                    fail_count;
    int                    outstanding;
    logic signed [POS_W-1:0] cur_pos_a, cur_pos_b, cur_pos_c;

    int beats_sent    = 0;
    int burst_left    = 0;
    int hold_requests = 0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    coordinated_three_axis_step_generator_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    ctasg_motion_checker motion_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .cur_pos_a   (cur_pos_a),
        .cur_pos_b   (cur_pos_b),
        .cur_pos_c   (cur_pos_c)
    );

    // Watchdog: a hung handshake or a lost result ends here.
    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

    // Result side. Cycle through its own modes (always ready, coin flip,
    // mostly stalled); on request hold m_ready low for a long stretch so the
    // result register fills and the block drops s_ready.
    initial begin
        int hold_served;
        int mode;
        int mode_left;
        hold_served = 0;
        mode        = 0;
        mode_left   = 0;
        m_ready     = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_served != hold_requests) begin
                hold_served++;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end else begin
                if (mode_left == 0) begin
                    mode      = int'($urandom_range(0, 2));
                    mode_left = int'($urandom_range(10, 120));
                end
                mode_left--;
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic ctasg_pkg::in_item_t make_cmd(input logic [1:0] op,
                                                     input logic [POS_W-1:0] ta,
                                                     input logic [POS_W-1:0] tb,
                                                     input logic [POS_W-1:0] tc,
                                                     input logic [SPD_W-1:0] feed);
        ctasg_pkg::in_item_t cmd;
        cmd.opcode            = op;
        cmd.target_position_a = ta;
        cmd.target_position_b = tb;
        cmd.target_position_c = tc;
        cmd.feedrate          = feed;
        return cmd;
    endfunction

    function automatic logic [POS_W-1:0] rand_pos();
        return POS_W'($urandom);
    endfunction

    function automatic logic [SPD_W-1:0] rand_feed();
        return SPD_W'($urandom_range(0, 65535));
    endfunction

    // Tick with junk in the unused fields; the block must ignore them.
    function automatic ctasg_pkg::in_item_t usec_tick();
        return make_cmd(ctasg_pkg::OP_TICK, rand_pos(), rand_pos(), rand_pos(), rand_feed());
    endfunction

    // Mostly fast feedrates (2000 and up); some zero, some anything.
    function automatic logic [SPD_W-1:0] pick_feedrate();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return rand_feed();
            default: return SPD_W'($urandom_range(2000, 65535));
        endcase
    endfunction

    // Small step offsets keep moves short enough to finish within a sequence.
    function automatic int near_offset();
        if ($urandom_range(0, 3) == 0) return int'($urandom_range(0, 8)) - 4;
        return int'($urandom_range(0, 2)) - 1;
    endfunction

    // Offer one beat at a falling edge, hold it until the handshake, then
    // either keep valid up for the next beat of the burst or drop it for a gap.
    task automatic send_beat(input ctasg_pkg::in_item_t cmd);
        int gap;
        s_data  <= cmd;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
        @(negedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(60, 150))
                                                     : int'($urandom_range(1, 20));
            gap        = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
    endtask

    // Drop valid, wait for every predicted report, then let the sequencer go idle.
    task automatic quiesce();
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_wdata <= val;
        cfg_wr_en <= 1'b1;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_phase(input logic [SPD_W-1:0] spd_a, input logic [SPD_W-1:0] spd_b,
                             input logic [SPD_W-1:0] spd_c, input logic [SPD_W-1:0] speed,
                             input logic enable);
        quiesce();
        write_reg(ctasg_pkg::REG_SPD_A, spd_a);
        write_reg(ctasg_pkg::REG_SPD_B, spd_b);
        write_reg(ctasg_pkg::REG_SPD_C, spd_c);
        write_reg(ctasg_pkg::REG_SPEED, speed);
        write_reg(ctasg_pkg::REG_DRIVE_EN, CFG_DATA_W'(enable));
    endtask

    // One stretch of traffic. Most are a short move near the current position
    // followed by ticks that step it toward the target, sometimes cut by a stop; the
    // rest are far moves that get stopped, raw noise, and zero-distance moves.
    task automatic run_sequence();
        int pick;
        int n;
        logic [POS_W-1:0] ga, gb, gc;
        pick = int'($urandom_range(0, 99));
        if (pick < 70) begin
            ga = POS_W'(int'(cur_pos_a) + near_offset());
            gb = POS_W'(int'(cur_pos_b) + near_offset());
            gc = POS_W'(int'(cur_pos_c) + near_offset());
            send_beat(make_cmd(ctasg_pkg::OP_MOVE, ga, gb, gc, pick_feedrate()));
            n = int'($urandom_range(10, 200));
            for (int i = 0; i < n; i++) begin
                if (i == n / 2 && $urandom_range(0, 3) == 0)
                    send_beat(make_cmd(ctasg_pkg::OP_STOP, rand_pos(), rand_pos(), rand_pos(),
                                       SPD_W'($urandom)));
                else
                    send_beat(usec_tick());
            end
        end else if (pick < 80) begin
            send_beat(make_cmd(ctasg_pkg::OP_MOVE, rand_pos(), rand_pos(), rand_pos(),
                               pick_feedrate()));
            repeat ($urandom_range(1, 30)) send_beat(usec_tick());
            send_beat(make_cmd(ctasg_pkg::OP_STOP, rand_pos(), rand_pos(), rand_pos(),
                               SPD_W'($urandom)));
        end else if (pick < 92) begin
            repeat ($urandom_range(1, 4))
                send_beat(make_cmd(2'($urandom_range(0, 3)), rand_pos(), rand_pos(),
                                   rand_pos(), rand_feed()));
        end else begin
            send_beat(make_cmd(ctasg_pkg::OP_MOVE, cur_pos_a, cur_pos_b, cur_pos_c,
                               pick_feedrate()));
            repeat ($urandom_range(1, 3)) send_beat(usec_tick());
        end
    endtask

    task automatic run_random(input int upto);
        while (beats_sent < upto) run_sequence();
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Drive still off after reset: move rejected, tick idles, stop still
        // acts, unused opcode with every payload bit set.
        send_beat(make_cmd(ctasg_pkg::OP_MOVE, 24'd100, -24'sd100, 24'd5, 16'd500));
        send_beat(usec_tick());
        send_beat(make_cmd(ctasg_pkg::OP_STOP, '0, '0, '0, '0));
        send_beat(make_cmd(OP_UNUSED, '1, '1, '1, '1));

        set_phase(ctasg_pkg::RESET_SPD, ctasg_pkg::RESET_SPD, ctasg_pkg::RESET_SPD,
                  ctasg_pkg::RESET_SPEED, 1'b1);

        // Move onto the current position: busy, then the next tick clears it.
        send_beat(make_cmd(ctasg_pkg::OP_MOVE, cur_pos_a, cur_pos_b, cur_pos_c, '0));
        send_beat(usec_tick());
        // Extreme targets at full feedrate; axis c stays put.
        send_beat(make_cmd(ctasg_pkg::OP_MOVE, 24'h7FFFFF, 24'h800000, cur_pos_c, 16'hFFFF));
        repeat (3) send_beat(usec_tick());
        send_beat(make_cmd(OP_UNUSED, '0, '0, '0, '0));
        send_beat(make_cmd(ctasg_pkg::OP_STOP, '1, '1, '1, '1));
        // Feedrate zero falls back to the default speed.
        send_beat(make_cmd(ctasg_pkg::OP_MOVE, POS_W'(int'(cur_pos_a) + 2),
                           POS_W'(int'(cur_pos_b) - 1), POS_W'(int'(cur_pos_c) + 1), '0));
        repeat (2) send_beat(usec_tick());
        send_beat(make_cmd(ctasg_pkg::OP_STOP, '0, '0, '0, '0));

        run_random(330);

        // Fastest settings; back the block up with a long result stall.
        set_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        hold_requests++;
        run_random(680);

        // Slowest settings: zero steps per degree on b saturates its period.
        set_phase(16'd1, 16'd0, 16'd777, 16'd1, 1'b1);
        run_random(930);

        // Drive off: moves bounce, ticks only count time, stops still act.
        set_phase(ctasg_pkg::RESET_SPD, ctasg_pkg::RESET_SPD, ctasg_pkg::RESET_SPD,
                  16'd0, 1'b0);
        run_random(1080);

        // Default speed zero: feedrate-zero moves divide by zero and saturate.
        set_phase(SPD_W'($urandom_range(1000, 65535)), SPD_W'($urandom_range(1000, 65535)),
                  SPD_W'($urandom_range(1000, 65535)), 16'd0, 1'b1);
        hold_requests++;
        run_random(1380);

        set_phase(rand_feed(), rand_feed(), rand_feed(), rand_feed(), 1'b1);
        run_random(1650);

        quiesce();
        if (fail_count == 0 && outstanding == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
